### rtl/core/padt_pkg.sv
// Package for the port allocate and demux table: sizes, operation and status codes,
// and the structs passed between the table store, the decision logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package padt_pkg;

   localparam int MODULE_COUNT = 256;
   localparam int PORT_COUNT   = 256;
   localparam int MODULE_AW    = $clog2(MODULE_COUNT);
   localparam int PORT_AW      = $clog2(PORT_COUNT);

   typedef enum logic [1:0] {
      OP_ASSIGN = 2'd0,
      OP_UP     = 2'd1,
      OP_DOWN   = 2'd2
   } padt_op_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_DUP          = 3'd1,
      ST_UNKNOWN_PORT = 3'd2,
      ST_NO_PORT      = 3'd3,
      ST_FULL         = 3'd4
   } padt_status_type;

   typedef struct packed {
      logic       en;
      logic [7:0] mid;
      logic [8:0] port;
   } padt_wr_type;

   typedef struct packed {
      logic       mid_valid;
      logic [8:0] mid_port;
      logic [7:0] port_owner;
      logic [8:0] issued;
   } padt_view_type;

   typedef struct packed {
      padt_status_type status;
      logic [8:0]      port;
      logic [7:0]      target_id;
   } padt_rsp_type;

endpackage

### rtl/core/padt_if.sv
// Valid/ready channel interfaces for request items and response items.
// No dependencies.
`timescale 1ns / 1ps

interface padt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  module_id;
   logic [15:0] dest_port;

   modport source (output valid, operation, module_id, dest_port, input ready);
   modport sink (input valid, operation, module_id, dest_port, output ready);
endinterface

interface padt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [8:0] port;
   logic [7:0] target_id;

   modport source (output valid, status, port, target_id, input ready);
   modport sink (input valid, status, port, target_id, output ready);
endinterface

### rtl/core/padt_tables.sv
// Table store: module-to-port and port-to-module memories, valid bits, issued count,
// registered reads with bypass of the write that lands on the read edge. Uses padt_pkg.
`timescale 1ns / 1ps

module padt_tables
   import padt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [7:0]    rd_mid,
   input  logic [15:0]   rd_dport,
   input  padt_wr_type   wr,
   output padt_view_type view
);

   logic [8:0]        pom_mem [MODULE_COUNT];
   logic [7:0]        mop_mem [PORT_COUNT];
   logic [MODULE_COUNT-1:0] valid_ff;
   logic [8:0]        issued_ff;
   logic [8:0]        issued_in;
   logic [8:0]        pom_rd_ff;
   logic [7:0]        mop_rd_ff;
   logic [7:0]        mid_ff;
   logic [15:0]       dport_ff;
   padt_wr_type       fwd_ff;
   logic [15:0]       rd_slot;
   logic [8:0]        wr_slot;

   assign rd_slot   = rd_dport - 16'd1;
   assign wr_slot   = wr.port - 9'd1;
   assign issued_in = wr.en ? issued_ff + 9'd1 : issued_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         pom_mem[wr.mid[MODULE_AW-1:0]] <= wr.port;
         mop_mem[wr_slot[PORT_AW-1:0]]  <= wr.mid;
      end
      if (rd_en) begin
         pom_rd_ff <= pom_mem[rd_mid[MODULE_AW-1:0]];
         mop_rd_ff <= mop_mem[rd_slot[PORT_AW-1:0]];
         mid_ff    <= rd_mid;
         dport_ff  <= rd_dport;
         fwd_ff    <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         issued_ff <= '0;
      end else begin
         issued_ff <= issued_in;
         if (wr.en) begin
            valid_ff[wr.mid[MODULE_AW-1:0]] <= 1'b1;
         end
      end
   end

   always_comb begin
      view.mid_valid  = valid_ff[mid_ff[MODULE_AW-1:0]];
      view.mid_port   = pom_rd_ff;
      view.port_owner = mop_rd_ff;
      view.issued     = issued_ff;
      if (fwd_ff.en && fwd_ff.mid == mid_ff) begin
         view.mid_port = fwd_ff.port;
      end
      if (fwd_ff.en && {7'd0, fwd_ff.port} == dport_ff) begin
         view.port_owner = fwd_ff.mid;
      end
   end

`ifndef SYNTHESIS
   a_issued_bound: assert property (@(posedge clock) disable iff (reset)
      32'(issued_ff) <= PORT_COUNT)
      else $error("issued count beyond port count");
   a_issued_step: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> issued_ff == $past(issued_ff) + 9'd1)
      else $error("issued count did not advance on assign");
   a_write_port: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> wr.port == issued_ff + 9'd1)
      else $error("assigned port is not the next sequential port");
`endif

endmodule

### rtl/core/padt_decide.sv
// Decision logic for one item: status, port and target id, and the table write of an assign.
// Uses padt_pkg.
`timescale 1ns / 1ps

module padt_decide
   import padt_pkg::*;
(
   input  logic [1:0]    operation,
   input  logic [7:0]    module_id,
   input  logic [15:0]   dest_port,
   input  padt_view_type view,
   output padt_rsp_type  rsp,
   output padt_wr_type   wr
);

   logic id_out;
   logic port_bad;

   assign id_out   = 32'(module_id) >= MODULE_COUNT;
   assign port_bad = dest_port == 16'd0 || dest_port > {7'd0, view.issued}
                     || 32'(dest_port) > PORT_COUNT;

   always_comb begin
      rsp.status    = ST_OK;
      rsp.port      = '0;
      rsp.target_id = '0;
      wr.en         = 1'b0;
      wr.mid        = module_id;
      wr.port       = view.issued + 9'd1;
      case (padt_op_type'(operation))
         OP_ASSIGN: begin
            if (id_out) begin
               rsp.status = ST_FULL;
            end else if (view.mid_valid) begin
               rsp.status = ST_DUP;
            end else if (32'(view.issued) >= PORT_COUNT) begin
               rsp.status = ST_FULL;
            end else begin
               rsp.port = view.issued + 9'd1;
               wr.en    = 1'b1;
            end
         end
         OP_UP: begin
            if (port_bad) begin
               rsp.status = ST_UNKNOWN_PORT;
            end else begin
               rsp.port      = dest_port[8:0];
               rsp.target_id = view.port_owner;
            end
         end
         OP_DOWN: begin
            if (id_out || !view.mid_valid) begin
               rsp.status = ST_NO_PORT;
            end else begin
               rsp.port = view.mid_port;
            end
         end
         default: begin
            rsp.status = ST_OK;
         end
      endcase
   end

endmodule

### rtl/core/port_allocate_and_demux_table.sv
// Port allocate and demux table: top level with request stage and response register.
// Uses padt_pkg, padt_if, padt_tables and padt_decide.
//
// Usage:
// The req channel carries an operation, a module id and a destination port. An assign
// hands the module id the next port number, starting from 1; an upward look-up maps a
// destination port to its owning module id; a downward look-up maps a module id to its
// port. The rsp channel returns one item per request with status, port and target id.
// A refused request leaves the tables unchanged.
// A request passes through the request stage, which registers the table reads, and then
// the response register, whose output is the rsp item. One item is accepted every cycle
// while rsp is not stalled; the table memories are read once per item and written once
// per successful assign, and a write is bypassed to the following item.
// When rsp is stalled the response is held, one more item is taken into the request
// stage, and req ready then drops until the response is taken.
// Reset clears the issued count and the module valid bits, so every module reads as
// having no port; both channels come up empty.
`timescale 1ns / 1ps

module port_allocate_and_demux_table
   import padt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   padt_req_if.sink    req,
   padt_rsp_if.source  rsp
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [1:0]    s1_op_ff;
   logic [7:0]    s1_mid_ff;
   logic [15:0]   s1_dport_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   padt_rsp_type  rsp_data_ff;
   padt_rsp_type  result;
   padt_wr_type   dec_wr;
   padt_wr_type   wr_cmd;
   padt_view_type view;
   logic          advance;
   logic          accept;
   logic          commit;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign commit  = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;
   assign accept  = req.valid && req.ready;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      wr_cmd    = dec_wr;
      wr_cmd.en = dec_wr.en && commit;
   end

   padt_tables u_tables (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_mid   (req.module_id),
      .rd_dport (req.dest_port),
      .wr       (wr_cmd),
      .view     (view)
   );

   padt_decide u_decide (
      .operation (s1_op_ff),
      .module_id (s1_mid_ff),
      .dest_port (s1_dport_ff),
      .view      (view),
      .rsp       (result),
      .wr        (dec_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req.operation;
         s1_mid_ff   <= req.module_id;
         s1_dport_ff <= req.dest_port;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_data_ff.status;
   assign rsp.port      = rsp_data_ff.port;
   assign rsp.target_id = rsp_data_ff.target_id;

`ifndef SYNTHESIS
   a_no_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.port == 9'd0 && rsp_data_ff.target_id == 8'd0)
      else $error("refused item carries a port or target id");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost from request stage");
   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("finished item not presented on response");
`endif

endmodule

### verif/padt_checker.sv
// Checker for the port allocate and demux table: watches both channels, predicts each
// reply from its own copy of the port tables and compares replies in order.
// Depends on padt_pkg and padt_if.
`timescale 1ns / 1ps

module padt_checker
   import padt_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   padt_req_if   req,
   padt_rsp_if   rsp,
   output int    fail_count,
   output int    pending,
   output int    replies_checked
);

   localparam int PRINT_LIMIT = 20;

   logic [8:0]   port_of_id [MODULE_COUNT];
   logic [7:0]   owner_of_port [PORT_COUNT];
   logic [8:0]   issued_ports;
   padt_rsp_type awaited_replies [$];
   padt_rsp_type want;

   initial begin
      fail_count      = 0;
      pending         = 0;
      replies_checked = 0;
   end

   task automatic report_error(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   // Works out the reply to one request and applies any table update it makes.
   function automatic padt_rsp_type resolve_request(input logic [1:0] op,
                                                    input logic [7:0] mid,
                                                    input logic [15:0] dport);
      padt_rsp_type r;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_ASSIGN: begin
            if (int'(mid) >= MODULE_COUNT) begin
               r.status = ST_FULL;
            end else if (port_of_id[mid] != 9'd0) begin
               r.status = ST_DUP;
            end else if (int'(issued_ports) >= PORT_COUNT) begin
               r.status = ST_FULL;
            end else begin
               issued_ports = issued_ports + 9'd1;
               port_of_id[mid] = issued_ports;
               owner_of_port[8'(issued_ports - 9'd1)] = mid;
               r.port = issued_ports;
            end
         end
         OP_UP: begin
            if (dport == 16'd0 || dport > issued_ports || int'(dport) > PORT_COUNT) begin
               r.status = ST_UNKNOWN_PORT;
            end else begin
               r.port = dport[8:0];
               r.target_id = owner_of_port[8'(dport - 16'd1)];
            end
         end
         OP_DOWN: begin
            if (int'(mid) >= MODULE_COUNT || port_of_id[mid] == 9'd0) begin
               r.status = ST_NO_PORT;
            end else begin
               r.port = port_of_id[mid];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODULE_COUNT; i++) port_of_id[i] = 9'd0;
         for (int i = 0; i < PORT_COUNT; i++) owner_of_port[i] = 8'd0;
         issued_ports = 9'd0;
         awaited_replies.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited_replies.size() == 0) begin
               report_error($sformatf("reply with no request waiting: status %0d port %0d id %0d",
                                      rsp.status, rsp.port, rsp.target_id));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp.status !== want.status)
                  report_error($sformatf("reply %0d status %0d, expected %0d",
                                         replies_checked, rsp.status, want.status));
               if (rsp.port !== want.port)
                  report_error($sformatf("reply %0d port %0d, expected %0d",
                                         replies_checked, rsp.port, want.port));
               if (rsp.target_id !== want.target_id)
                  report_error($sformatf("reply %0d target id %0d, expected %0d",
                                         replies_checked, rsp.target_id, want.target_id));
               replies_checked++;
            end
         end
         if (req.valid && req.ready) begin
            awaited_replies.push_back(resolve_request(req.operation, req.module_id,
                                                      req.dest_port));
         end
      end
      pending = awaited_replies.size();
   end

endmodule

### verif/tb_port_allocate_and_demux_table.sv
// Testbench top for the port allocate and demux table: clock, reset, request stimulus,
// reply back-pressure, watchdog and verdict. Depends on padt_pkg, padt_if, the block
// and padt_checker.
`timescale 1ns / 1ps

module tb_port_allocate_and_demux_table;
   import padt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES  = 96;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;
   logic idle_on;
   logic hold_wanted;
   logic hold_done = 1'b0;
   int   fail_count;
   int   pending;
   int   replies_checked;
   int   sent_count [4] = '{0, 0, 0, 0};
   int   id_order [MODULE_COUNT];
   int   order_next;
   int   stalled;

   padt_req_if req_ch ();
   padt_rsp_if rsp_ch ();

   port_allocate_and_demux_table DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   padt_checker CHECK (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .fail_count      (fail_count),
      .pending         (pending),
      .replies_checked (replies_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] mid,
                            input logic [15:0] dport);
      while (idle_on && $urandom_range(99) < 34) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.operation = op;
      req_ch.module_id = mid;
      req_ch.dest_port = dport;
      sent_count[op]++;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [1:0]  op;
      logic [7:0]  mid;
      logic [15:0] dport;
      int          pick;
      pick  = $urandom_range(99);
      mid   = 8'($urandom_range(255));
      dport = 16'($urandom_range(65535));
      if (pick < 30) begin
         op = OP_ASSIGN;
         if ($urandom_range(3) != 0 && order_next < MODULE_COUNT) begin
            mid = 8'(id_order[order_next]);
            order_next++;
         end
      end else if (pick < 65) begin
         op = OP_UP;
         case ($urandom_range(9))
            0: dport = 16'($urandom_range(65535));
            1: begin
               case ($urandom_range(3))
                  0: dport = 16'd0;
                  1: dport = 16'hFFFF;
                  2: dport = 16'd256;
                  default: dport = 16'd257;
               endcase
            end
            default: dport = 16'($urandom_range(260, 1));
         endcase
      end else if (pick < 92) begin
         op = OP_DOWN;
      end else begin
         op = OP_UNUSED;
      end
      send_item(op, mid, dport);
   endtask

   // The reply side: random back-pressure, plus one long hold requested by the sender.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ch.ready = !(idle_on && $urandom_range(99) < 34);
      end
   end

   initial begin
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Watchdog: no item moved for %0d cycles, %0d replies outstanding",
               STALL_LIMIT, pending);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int swap_at;
      int held;
      reset            = 1'b1;
      idle_on          = 1'b0;
      hold_wanted      = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_ASSIGN;
      req_ch.module_id = 8'd0;
      req_ch.dest_port = 16'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table, unused operation, first assigns, duplicate and back-to-back look-ups.
      send_item(OP_UP, 8'd0, 16'd0);
      send_item(OP_UP, 8'hFF, 16'hFFFF);
      send_item(OP_UP, 8'd0, 16'd1);
      send_item(OP_DOWN, 8'd0, 16'd0);
      send_item(OP_DOWN, 8'hFF, 16'hFFFF);
      send_item(OP_UNUSED, 8'hFF, 16'hFFFF);
      send_item(OP_ASSIGN, 8'hFF, 16'd0);
      send_item(OP_ASSIGN, 8'd0, 16'hFFFF);
      send_item(OP_ASSIGN, 8'hFF, 16'd0);
      send_item(OP_UP, 8'd0, 16'd1);
      send_item(OP_UP, 8'd0, 16'd2);
      send_item(OP_UP, 8'd0, 16'd3);
      send_item(OP_DOWN, 8'hFF, 16'd0);
      send_item(OP_DOWN, 8'd0, 16'd0);
      send_item(OP_UNUSED, 8'd0, 16'd0);
      send_item(OP_ASSIGN, 8'hAA, 16'h5555);
      send_item(OP_UP, 8'h55, 16'd3);
      send_item(OP_DOWN, 8'hAA, 16'd0);
      send_item(OP_DOWN, 8'h55, 16'hAAAA);
      send_item(OP_UP, 8'd0, 16'hFFFF);

      for (int i = 0; i < MODULE_COUNT; i++) id_order[i] = i;
      for (int i = MODULE_COUNT - 1; i > 0; i--) begin
         swap_at = $urandom_range(i);
         held = id_order[i];
         id_order[i] = id_order[swap_at];
         id_order[swap_at] = held;
      end
      order_next = 0;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 1100 && n < 1400);
         if (n == 300) hold_wanted = 1'b1;
         if (n == 700) begin
            req_ch.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         send_random_item();
      end
      req_ch.valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d requests (%0d assign, %0d upward, %0d downward, %0d unused),",
               sent_count[0] + sent_count[1] + sent_count[2] + sent_count[3],
               sent_count[0], sent_count[1], sent_count[2], sent_count[3]);
      $display("checked %0d replies across a long reply stall and a full drain pause.",
               replies_checked);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/padt_pkg.sv
rtl/core/padt_if.sv
rtl/core/padt_tables.sv
rtl/core/padt_decide.sv
rtl/core/port_allocate_and_demux_table.sv
verif/padt_checker.sv
verif/tb_port_allocate_and_demux_table.sv
